/* rtl/zoc_pkg.sv */
package zoc_pkg;

   localparam int MAX_TRANSITIONS = 512;
   localparam int MAX_TYPES       = 16;
   localparam int TR_AW = $clog2(MAX_TRANSITIONS);
   localparam int TR_CW = $clog2(MAX_TRANSITIONS + 1);
   localparam int TY_AW = $clog2(MAX_TYPES);
   localparam int TY_CW = $clog2(MAX_TYPES + 1);

   typedef enum logic [1:0] {
      ACT_LOAD_TRANS = 2'd0,
      ACT_LOAD_TYPE  = 2'd1,
      ACT_TO_WALL    = 2'd2,
      ACT_FROM_WALL  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_VALID       = 3'd0,
      ST_AMBIGUOUS   = 3'd1,
      ST_NONEXISTENT = 3'd2,
      ST_NO_DATA     = 3'd3,
      ST_BAD_LOAD    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_TRANSITION_COUNT = 2'd0,
      CSR_TYPE_COUNT       = 2'd1,
      CSR_ZONE_IS_UTC      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [8:0]         slot;
      logic signed [63:0] seconds;
      logic [3:0]         type_slot;
      logic signed [31:0] utc_offset;
      logic               daylight;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [63:0] result_seconds;
      logic [3:0]         type_used;
      logic               daylight_used;
      logic signed [31:0] offset_used;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_RES_UTC,
      OP_RES_NODATA,
      OP_SRCH_INIT,
      OP_FW_INIT,
      OP_CAND,
      OP_SRCH_READ,
      OP_SRCH_STEP,
      OP_KIND_READ,
      OP_RESOLVE,
      OP_TW_RES,
      OP_MATCH,
      OP_NEXT_I,
      OP_FW_RES,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       is_utc;
      logic       nt_zero;
      logic       lo_lt_hi;
      logic       lo_nz;
      logic       drop;
      logic       last_i;
      logic       out_free;
   } sts_type;

endpackage

/* rtl/zoc_ctrl.sv */
module zoc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  zoc_pkg::sts_type sts,
   output zoc_pkg::cmd_type cmd
);
   import zoc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_CAND, S_CAND_CHK, S_SRCH, S_SRCH_CMP,
      S_RESOLVE, S_TW_OUT, S_MATCH, S_NEXT, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_EMIT;
            if (sts.action == ACT_LOAD_TRANS || sts.action == ACT_LOAD_TYPE) begin
               cmd.op = OP_LOAD;
            end else if (sts.is_utc) begin
               cmd.op = OP_RES_UTC;
            end else if (sts.nt_zero) begin
               cmd.op = OP_RES_NODATA;
            end else if (sts.action == ACT_TO_WALL) begin
               cmd.op   = OP_SRCH_INIT;
               state_in = S_SRCH;
            end else begin
               cmd.op   = OP_FW_INIT;
               state_in = S_CAND;
            end
         end
         S_CAND: begin
            cmd.op   = OP_CAND;
            state_in = S_CAND_CHK;
         end
         S_CAND_CHK: begin
            state_in = sts.drop ? S_NEXT : S_SRCH;
         end
         S_SRCH: begin
            if (sts.lo_lt_hi) begin
               cmd.op   = OP_SRCH_READ;
               state_in = S_SRCH_CMP;
            end else if (sts.lo_nz) begin
               cmd.op   = OP_KIND_READ;
               state_in = S_RESOLVE;
            end else begin
               state_in = S_RESOLVE;
            end
         end
         S_SRCH_CMP: begin
            cmd.op   = OP_SRCH_STEP;
            state_in = S_SRCH;
         end
         S_RESOLVE: begin
            cmd.op   = OP_RESOLVE;
            state_in = (sts.action == ACT_FROM_WALL) ? S_MATCH : S_TW_OUT;
         end
         S_TW_OUT: begin
            cmd.op   = OP_TW_RES;
            state_in = S_EMIT;
         end
         S_MATCH: begin
            cmd.op   = OP_MATCH;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (sts.last_i) begin
               cmd.op   = OP_FW_RES;
               state_in = S_EMIT;
            end else begin
               cmd.op   = OP_NEXT_I;
               state_in = S_CAND;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> sts.out_free)
      else $error("emit while result register busy");
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_CAPTURE |=> req_stall)
      else $error("input not held off after capture");
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_SRCH_READ |-> sts.lo_lt_hi)
      else $error("search read with empty range");

endmodule

/* rtl/zoc_dp.sv */
module zoc_dp (
   input  logic             clock,
   input  logic             reset,
   input  zoc_pkg::req_type req_payload,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic [9:0]       csr_data,
   input  zoc_pkg::cmd_type cmd,
   output zoc_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output zoc_pkg::rsp_type rsp_payload
);
   import zoc_pkg::*;

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

   logic [63:0] tr_time_mem [MAX_TRANSITIONS];
   logic [3:0]  tr_kind_mem [MAX_TRANSITIONS];
   logic signed [31:0] ty_off_ff [MAX_TYPES];
   logic               ty_dl_ff  [MAX_TYPES];

   req_type            req_ff;
   logic [9:0]         tcount_ff;
   logic [4:0]         tycount_ff;
   logic               utc_ff;
   logic signed [63:0] rd_time_ff;
   logic [3:0]         rd_kind_ff;
   logic signed [63:0] x_ff;
   logic [TR_CW-1:0]   lo_ff, hi_ff;
   logic [TR_AW-1:0]   mid_ff;
   logic signed [31:0] o_ff;
   logic               drop_ff;
   logic [TY_AW-1:0]   ty_ff, i_ff, bty_ff;
   logic               bad_ff, found_ff, amb_ff, bdl_ff;
   logic signed [63:0] best_ff;
   logic signed [31:0] boff_ff;
   rsp_type            res_ff, rsp_ff;
   logic               rsp_valid_ff;

   logic [TR_CW-1:0]   ntr;
   logic [TY_CW-1:0]   nt;
   logic [TR_CW-1:0]   mid_full;
   logic [TY_AW-1:0]   ty_addr, fb;
   logic signed [31:0] rd_off;
   logic               rd_dl;
   logic [64:0]        sum, diff;
   logic signed [63:0] sat;
   logic               hit;
   logic               load_bad;

   assign ntr = (tcount_ff > TR_CW'(MAX_TRANSITIONS)) ? TR_CW'(MAX_TRANSITIONS) : tcount_ff;
   assign nt  = (tycount_ff > TY_CW'(MAX_TYPES)) ? TY_CW'(MAX_TYPES) : tycount_ff;
   assign mid_full = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign ty_addr  = (cmd.op == OP_CAND) ? i_ff : ty_ff;
   assign rd_off   = ty_off_ff[ty_addr];
   assign rd_dl    = ty_dl_ff[ty_addr];
   assign sum  = {req_ff.seconds[63], req_ff.seconds} + {{33{rd_off[31]}}, rd_off};
   assign diff = {req_ff.seconds[63], req_ff.seconds} - {{33{rd_off[31]}}, rd_off};
   assign sat  = (sum[64] != sum[63]) ? (sum[64] ? S64_MIN : S64_MAX) : $signed(sum[63:0]);
   assign hit  = !bad_ff && (rd_off == o_ff);
   assign load_bad = (req_ff.action == ACT_LOAD_TYPE)
                   ? (TR_CW'(req_ff.slot) >= TR_CW'(MAX_TYPES))
                   : (TY_CW'(req_ff.type_slot) >= TY_CW'(MAX_TYPES)
                      || TR_CW'(req_ff.slot) >= TR_CW'(MAX_TRANSITIONS));

   always_comb begin
      fb = '0;
      for (int k = MAX_TYPES - 1; k >= 0; k--) begin
         if (TY_CW'(k) < nt && !ty_dl_ff[TY_AW'(k)]) begin
            fb = TY_AW'(k);
         end
      end
   end

   assign sts.action   = req_ff.action;
   assign sts.is_utc   = utc_ff;
   assign sts.nt_zero  = (nt == '0);
   assign sts.lo_lt_hi = (lo_ff < hi_ff);
   assign sts.lo_nz    = (lo_ff != '0);
   assign sts.drop     = drop_ff;
   assign sts.last_i   = ({1'b0, i_ff} == nt - TY_CW'(1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && req_ff.action == ACT_LOAD_TRANS
          && TR_CW'(req_ff.slot) < TR_CW'(MAX_TRANSITIONS)) begin
         tr_time_mem[req_ff.slot[TR_AW-1:0]] <= req_ff.seconds;
         tr_kind_mem[req_ff.slot[TR_AW-1:0]] <= req_ff.type_slot;
      end
      if (cmd.op == OP_SRCH_READ) begin
         rd_time_ff <= tr_time_mem[mid_full[TR_AW-1:0]];
      end
      if (cmd.op == OP_KIND_READ) begin
         rd_kind_ff <= tr_kind_mem[TR_AW'(lo_ff - TR_CW'(1))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tcount_ff    <= '0;
         tycount_ff   <= '0;
         utc_ff       <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_TRANSITION_COUNT: tcount_ff  <= csr_data;
               CSR_TYPE_COUNT:       tycount_ff <= csr_data[4:0];
               CSR_ZONE_IS_UTC:      utc_ff     <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_SRCH_INIT, OP_CAND: begin
               lo_ff <= '0;
               hi_ff <= ntr;
            end
            OP_SRCH_STEP: begin
               if (rd_time_ff <= x_ff) begin
                  lo_ff <= {1'b0, mid_ff} + TR_CW'(1);
               end else begin
                  hi_ff <= {1'b0, mid_ff};
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            req_ff <= req_payload;
         end
         OP_LOAD: begin
            res_ff <= {(load_bad ? ST_BAD_LOAD : ST_VALID), 64'd0, 4'd0, 1'b0, 32'd0};
            if (req_ff.action == ACT_LOAD_TYPE && !load_bad) begin
               ty_off_ff[req_ff.slot[TY_AW-1:0]] <= req_ff.utc_offset;
               ty_dl_ff[req_ff.slot[TY_AW-1:0]]  <= req_ff.daylight;
            end
         end
         OP_RES_UTC: begin
            res_ff <= {ST_VALID, req_ff.seconds, 4'd0, 1'b0, 32'd0};
         end
         OP_RES_NODATA: begin
            res_ff <= {ST_NO_DATA, 64'd0, 4'd0, 1'b0, 32'd0};
         end
         OP_SRCH_INIT: begin
            x_ff <= req_ff.seconds;
         end
         OP_FW_INIT: begin
            i_ff     <= '0;
            found_ff <= 1'b0;
            amb_ff   <= 1'b0;
         end
         OP_CAND: begin
            o_ff    <= rd_off;
            x_ff    <= $signed(diff[63:0]);
            drop_ff <= (diff[64] != diff[63]);
         end
         OP_SRCH_READ: begin
            mid_ff <= mid_full[TR_AW-1:0];
         end
         OP_RESOLVE: begin
            if (lo_ff != '0) begin
               ty_ff  <= rd_kind_ff[TY_AW-1:0];
               bad_ff <= ({1'b0, rd_kind_ff} >= nt);
            end else begin
               ty_ff  <= fb;
               bad_ff <= 1'b0;
            end
         end
         OP_TW_RES: begin
            if (bad_ff) begin
               res_ff <= {ST_NO_DATA, 64'd0, 4'd0, 1'b0, 32'd0};
            end else begin
               res_ff <= {ST_VALID, sat, ty_ff, rd_dl, rd_off};
            end
         end
         OP_MATCH: begin
            if (hit) begin
               if (!found_ff || x_ff < best_ff) begin
                  best_ff <= x_ff;
                  bty_ff  <= ty_ff;
                  bdl_ff  <= rd_dl;
                  boff_ff <= rd_off;
               end
               if (found_ff && x_ff != best_ff) begin
                  amb_ff <= 1'b1;
               end
               found_ff <= 1'b1;
            end
         end
         OP_NEXT_I: begin
            i_ff <= i_ff + TY_AW'(1);
         end
         OP_FW_RES: begin
            if (!found_ff) begin
               res_ff <= {ST_NONEXISTENT, 64'd0, 4'd0, 1'b0, 32'd0};
            end else begin
               res_ff <= {(amb_ff ? ST_AMBIGUOUS : ST_VALID), best_ff, bty_ff, bdl_ff,
                          boff_ff};
            end
         end
         OP_EMIT: begin
            rsp_ff <= res_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff && hi_ff <= TR_CW'(MAX_TRANSITIONS))
      else $error("search bounds out of order");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == OP_EMIT))
      else $error("result raised without emit");
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_MATCH && found_ff |=> found_ff)
      else $error("match state lost");

endmodule

/* rtl/zone_offset_converter_top.sv */
// Channel   Direction  Handshake            Beat
// req_      in         req_valid/req_stall  req_type: action, slot, seconds, offsets
// rsp_      out        rsp_valid/rsp_stall  rsp_type: status, result, applied type
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
// Loads skip the search; to_wall runs one binary search over the n transitions, and
// from_wall runs one for each of the T types whose shifted time does not overflow,
// reading the transition memory once per search step.
// One request is in work at a time; the result register lets the next request in
// while a result beat waits on rsp_stall. Reset is synchronous and clears the state,
// CSRs, bounds, rsp_valid; tables hold garbage until loaded. csr_ready is always high.
module zone_offset_converter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  zoc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output zoc_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [9:0]       csr_data
);
   import zoc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   zoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   zoc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
